@@ sv/expiry_ordered_timer_queue_top_macros.svh @@
// Assertion macros for the expiry-ordered timer queue
`ifndef EXPIRY_ORDERED_TIMER_QUEUE_TOP_MACROS_SVH
`define EXPIRY_ORDERED_TIMER_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define EOTQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define EOTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/eotq_pkg.sv @@
// Package: shared types and codes for the expiry-ordered timer queue
`timescale 1ns / 1ps
`default_nettype none
package eotq_pkg;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [2:0] EV_CREATED   = 3'd0;
  localparam logic [2:0] EV_DESTROYED = 3'd1;
  localparam logic [2:0] EV_FIRED     = 3'd2;
  localparam logic [2:0] EV_FULL      = 3'd3;
  localparam logic [2:0] EV_NOT_FOUND = 3'd4;

  // most timers fired by one tick
  localparam int unsigned MAX_FIRE  = 16;
  localparam int unsigned FIRE_CNTW = $clog2(MAX_FIRE);

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [31:0] duration_ms;
    logic [31:0] jitter_range;
    logic [31:0] random_word;
    logic [31:0] target_handle;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] handle;
    logic [31:0] expiry_ms;
    logic        last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic scan_start;
    logic resolve;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       div_done;
    logic       scan_done;
    logic       found;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

@@ sv/eotq_ifs.sv @@
// Valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
`default_nettype none
interface eotq_in_if;
  logic          valid;
  logic          ready;
  eotq_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eotq_out_if;
  logic           valid;
  logic           ready;
  eotq_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/eotq_div.sv @@
// Restoring radix-2 remainder unit, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module eotq_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      rem_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_q, dvd_q[31]};
  assign diff    = shifted - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 32'd0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = (shifted >= {1'b0, divisor_i}) ? diff[31:0] : shifted[31:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  // remainder is final in the cycle done_o is high
  assign rem_o = rem_d;

endmodule
`default_nettype wire

@@ sv/eotq_datapath.sv @@
// Datapath: timer table memory, scan/compare pipe, expiry math, result register
`timescale 1ns / 1ps
`default_nettype none
module eotq_datapath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire eotq_pkg::in_t   in_data_i,
  input  wire eotq_pkg::cmd_t  cmd_i,
  output eotq_pkg::status_t    status_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output eotq_pkg::out_t       out_data_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  // latched request
  logic [1:0]  op_q;
  logic [31:0] now_q, tgt_q, jit_q, rnd_q, exp_q;

  // table
  logic [63:0]            mem_q [TABLE_DEPTH];
  logic [63:0]            rdata_q;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [31:0]            next_handle_q;

  // scan pipe
  logic            issue_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            found_q;
  logic [IdxW-1:0] best_idx_q;
  logic [31:0]     best_exp_q, best_h_q;

  // pending fired timer of a tick, held until we know if it is the last
  logic        pend_vld_q;
  logic [31:0] pend_h_q, pend_exp_q;

  logic           out_vld_q;
  eotq_pkg::out_t out_q;

  logic           div_done;
  logic [31:0]    div_rem;

  logic [31:0] c_exp, c_h;
  logic        c_valid, hit;

  logic           load_out, wr_en, set_v, clr_v, pend_load, pend_clr, hnd_inc;
  eotq_pkg::out_t out_d;

  eotq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rnd_q),
    .divisor_i  (jit_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign c_exp   = rdata_q[63:32];
  assign c_h     = rdata_q[31:0];
  assign c_valid = valid_q[cmp_idx_q];

  always_comb begin
    case (op_q)
      eotq_pkg::OP_CREATE:  hit = !c_valid && !found_q;
      eotq_pkg::OP_DESTROY: hit = c_valid && (c_h == tgt_q) && !found_q;
      eotq_pkg::OP_TICK:    hit = c_valid && (c_exp <= now_q) &&
                                  (!found_q || (c_exp < best_exp_q) ||
                                   ((c_exp == best_exp_q) && (c_h < best_h_q)));
      default:              hit = 1'b0;
    endcase
  end

  always_comb begin
    load_out  = 1'b0;
    wr_en     = 1'b0;
    set_v     = 1'b0;
    clr_v     = 1'b0;
    pend_load = 1'b0;
    pend_clr  = 1'b0;
    hnd_inc   = 1'b0;
    out_d     = '{event_kind: eotq_pkg::EV_FIRED, handle: pend_h_q,
                  expiry_ms: pend_exp_q, last: 1'b1};
    if (cmd_i.resolve) begin
      case (op_q)
        eotq_pkg::OP_CREATE: begin
          load_out = 1'b1;
          if (found_q) begin
            wr_en   = 1'b1;
            set_v   = 1'b1;
            hnd_inc = 1'b1;
            out_d   = '{event_kind: eotq_pkg::EV_CREATED, handle: next_handle_q,
                        expiry_ms: exp_q, last: 1'b1};
          end else begin
            out_d = '{event_kind: eotq_pkg::EV_FULL, handle: 32'd0,
                      expiry_ms: 32'd0, last: 1'b1};
          end
        end
        eotq_pkg::OP_DESTROY: begin
          load_out = 1'b1;
          if (found_q) begin
            clr_v = 1'b1;
            out_d = '{event_kind: eotq_pkg::EV_DESTROYED, handle: tgt_q,
                      expiry_ms: best_exp_q, last: 1'b1};
          end else begin
            out_d = '{event_kind: eotq_pkg::EV_NOT_FOUND, handle: tgt_q,
                      expiry_ms: 32'd0, last: 1'b1};
          end
        end
        eotq_pkg::OP_TICK: begin
          if (found_q) begin
            clr_v      = 1'b1;
            pend_load  = 1'b1;
            load_out   = pend_vld_q;
            out_d.last = 1'b0;
          end else begin
            load_out = pend_vld_q;
            pend_clr = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.flush) begin
      load_out = 1'b1;
      pend_clr = 1'b1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (set_v) valid_d[best_idx_q] = 1'b1;
    if (clr_v) valid_d[best_idx_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      next_handle_q <= 32'd0;
      issue_q       <= 1'b0;
      rd_idx_q      <= '0;
      cmp_vld_q     <= 1'b0;
      cmp_idx_q     <= '0;
      found_q       <= 1'b0;
      pend_vld_q    <= 1'b0;
      out_vld_q     <= 1'b0;
      op_q          <= 2'd0;
    end else begin
      valid_q <= valid_d;
      if (hnd_inc) next_handle_q <= next_handle_q + 32'd1;
      if (cmd_i.accept) op_q <= in_data_i.op;

      if (cmd_i.scan_start) begin
        issue_q  <= 1'b1;
        rd_idx_q <= '0;
      end else if (issue_q) begin
        if (rd_idx_q == LastIdx) issue_q <= 1'b0;
        else rd_idx_q <= rd_idx_q + IdxW'(1);
      end
      cmp_vld_q <= issue_q && !cmd_i.scan_start;
      cmp_idx_q <= rd_idx_q;

      if (cmd_i.scan_start) found_q <= 1'b0;
      else if (cmp_vld_q && hit) found_q <= 1'b1;

      if (pend_load) pend_vld_q <= 1'b1;
      else if (pend_clr) pend_vld_q <= 1'b0;

      if (load_out) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q <= in_data_i.now_ms;
      tgt_q <= in_data_i.target_handle;
      jit_q <= in_data_i.jitter_range;
      rnd_q <= in_data_i.random_word;
      exp_q <= in_data_i.now_ms + in_data_i.duration_ms;
    end else if (div_done && (jit_q != 32'd0)) begin
      exp_q <= exp_q + div_rem;
    end
    if (cmp_vld_q && hit) begin
      best_idx_q <= cmp_idx_q;
      best_exp_q <= c_exp;
      best_h_q   <= c_h;
    end
    if (pend_load) begin
      pend_h_q   <= best_h_q;
      pend_exp_q <= best_exp_q;
    end
    if (load_out) out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[best_idx_q] <= {exp_q, next_handle_q};
    rdata_q <= mem_q[rd_idx_q];
  end

  assign status_o = '{op: op_q, div_done: div_done,
                      scan_done: cmp_vld_q && (cmp_idx_q == LastIdx),
                      found: found_q, out_free: !out_vld_q || out_ready_i};

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ sv/eotq_ctrl.sv @@
// Controller: sequences divide, table scans and result hand-off per request
`timescale 1ns / 1ps
`default_nettype none
module eotq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire eotq_pkg::status_t status_i,
  output eotq_pkg::cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_RESOLVE  = 3'd4;
  localparam logic [2:0] S_FLUSH    = 3'd5;

  localparam logic [eotq_pkg::FIRE_CNTW-1:0] FireLast =
    eotq_pkg::FIRE_CNTW'(eotq_pkg::MAX_FIRE - 1);

  logic [2:0]                       state_q, state_d;
  logic [eotq_pkg::FIRE_CNTW-1:0]   fire_q, fire_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    fire_d  = fire_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        fire_d = '0;
        case (status_i.op)
          eotq_pkg::OP_CREATE: begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
          eotq_pkg::OP_DESTROY, eotq_pkg::OP_TICK: begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.scan_done) state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (status_i.out_free) begin
          cmd_o.resolve = 1'b1;
          if ((status_i.op == eotq_pkg::OP_TICK) && status_i.found) begin
            fire_d = fire_q + eotq_pkg::FIRE_CNTW'(1);
            if (fire_q == FireLast) begin
              state_d = S_FLUSH;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fire_q  <= '0;
    end else begin
      state_q <= state_d;
      fire_q  <= fire_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/expiry_ordered_timer_queue_top.sv @@
// Top level: expiry-ordered timer queue, controller plus datapath
// Sequence: create runs the remainder unit, then a free-slot scan; destroy runs one scan;
//   tick scans the table again after each fired timer, up to 16 of them, and each result
//   may be held by an output stall.
// Throughput: one request at a time; the next is taken once the last result is in the
//   output register. The single-port table read sets the scan length.
// Reset: rst_ni async active low clears slot valid bits, next handle and all control.
`timescale 1ns / 1ps
`default_nettype none
`include "expiry_ordered_timer_queue_top_macros.svh"
module expiry_ordered_timer_queue_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  eotq_in_if.sink     in_i,
  eotq_out_if.source  out_o
);

  eotq_pkg::cmd_t    cmd;
  eotq_pkg::status_t status;

  // Controller: owns the request handshake and steps each request through
  // divide, scan and resolve phases.
  eotq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: table, compare pipe and the output register that decouples
  // the result side from the next request. Table memory contents are left
  // as is over reset and only read behind a valid bit.
  eotq_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  // One request in flight: ready drops right after a request is taken.
  `EOTQ_ASSERT_NEXT(a_one_inflight, in_i.valid && in_i.ready, !in_i.ready, "request overlap")

  // Only fired timers can be non-final.
  `EOTQ_ASSERT_IMPL(a_last_nonfire, out_o.valid && (out_o.data.event_kind != eotq_pkg::EV_FIRED), out_o.data.last, "non-tick result without last")

  // Table full carries zero handle and expiry.
  `EOTQ_ASSERT_IMPL(a_full_zero, out_o.valid && (out_o.data.event_kind == eotq_pkg::EV_FULL), (out_o.data.handle == 32'd0) && (out_o.data.expiry_ms == 32'd0), "bad full result")

endmodule
`default_nettype wire
